// ===== src/contiguous_block_allocator_assert.svh =====
// Assertion macros used by the allocator top level.
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

// ===== src/cba_pkg.sv =====
// Shared types, codes and constants of the contiguous block allocator.
package cba_pkg;

  localparam int DEF_NBLOCKS = 256;

  localparam int SIZE_W   = 17;
  localparam int COUNT_W  = 9;
  localparam int LENGTH_W = 32;
  localparam int BLKID_W  = 8;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RST  = 17'd1024;
  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 9'd256;

  // Register select, taken from the word address bit of paddr.
  localparam logic REG_BLOCK_SIZE  = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  localparam logic [1:0] ACT_SET_TYPE  = 2'd0;
  localparam logic [1:0] ACT_FIND_RUN  = 2'd1;
  localparam logic [1:0] ACT_FIND_FREE = 2'd2;

  localparam logic [1:0] TYPE_UNUSED = 2'd0;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  typedef struct packed {
    logic [1:0]          action;
    logic [BLKID_W-1:0]  block_id;
    logic [1:0]          new_type;
    logic [LENGTH_W-1:0] length;
  } cmd_t;

  typedef struct packed {
    logic               status;
    logic [BLKID_W-1:0] start_block;
    logic [BLKID_W-1:0] end_block;
  } rsp_t;

endpackage

// ===== src/cba_cell.sv =====
// One cell of the allocator chain: holds one block's type and advances the search wave.
module cba_cell import cba_pkg::*; #(
  parameter int NBLOCKS = DEF_NBLOCKS,
  parameter int INDEX   = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic [((($clog2(NBLOCKS)) > BLKID_W) ? $clog2(NBLOCKS) : BLKID_W)-1:0] wr_id,
  input  logic [1:0] wr_type,
  input  logic [$clog2(NBLOCKS+2)-1:0] need,
  input  logic [$clog2(NBLOCKS+2)-1:0] used,
  input  logic prev_valid,
  input  logic prev_found,
  input  logic [$clog2(NBLOCKS+2)-1:0] prev_len,
  input  logic [$clog2(NBLOCKS)-1:0] prev_start,
  output logic next_valid,
  output logic next_found,
  output logic [$clog2(NBLOCKS+2)-1:0] next_len,
  output logic [$clog2(NBLOCKS)-1:0] next_start
);

  localparam int IDX_W = $clog2(NBLOCKS);
  localparam int LEN_W = $clog2(NBLOCKS + 2);
  localparam int IDW   = (IDX_W > BLKID_W) ? IDX_W : BLKID_W;

  logic [1:0]       typ;
  logic             eligible;
  logic             found_next;
  logic [LEN_W-1:0] len_next;
  logic [IDX_W-1:0] start_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      typ <= TYPE_UNUSED;
    end else if (wr_en && (wr_id == IDW'(INDEX))) begin
      typ <= wr_type;
    end
  end

  // Blocks at or beyond the used count behave as occupied.
  assign eligible = (typ == TYPE_UNUSED) && (LEN_W'(INDEX) < used);

  always_comb begin
    found_next = prev_found;
    len_next   = prev_len;
    start_next = prev_start;
    if (!prev_found) begin
      if (eligible) begin
        len_next = prev_len + LEN_W'(1);
        if (prev_len == '0) begin
          start_next = IDX_W'(INDEX);
        end
        found_next = (len_next >= need);
      end else begin
        len_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_valid <= 1'b0;
    end else begin
      next_valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    next_found <= found_next;
    next_len   <= len_next;
    next_start <= start_next;
  end

endmodule

// ===== src/cba_div.sv =====
// Radix-2 restoring divider that turns a byte length into a block quotient and remainder flag.
module cba_div import cba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [LENGTH_W-1:0] dividend,
  input  logic [SIZE_W-1:0]   divisor,
  output logic                done,
  output logic [LENGTH_W-1:0] quotient,
  output logic                rem_nz
);

  localparam int STEP_W = $clog2(LENGTH_W);

  logic [LENGTH_W-1:0] quo;
  logic [SIZE_W-1:0]   rem;
  logic [SIZE_W-1:0]   rem_next;
  logic [SIZE_W:0]     shifted;
  logic                ge;
  logic [STEP_W-1:0]   count;
  logic                running;

  assign shifted = {rem, quo[LENGTH_W-1]};
  assign ge      = (shifted >= {1'b0, divisor});
  // The partial remainder stays below the divisor, so it fits the divisor's width.
  assign rem_next = ge ? SIZE_W'(shifted - {1'b0, divisor}) : shifted[SIZE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= '0;
      end else if (running) begin
        count <= count + STEP_W'(1);
        if (count == STEP_W'(LENGTH_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (running) begin
      quo <= {quo[LENGTH_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quotient = quo;
  assign rem_nz   = |rem;

endmodule

// ===== src/contiguous_block_allocator.sv =====
// Top level of the first-fit contiguous block allocator.
//
// The allocator keeps a 2-bit type code for each of NBLOCKS blocks, cleared to unused at
// reset, in a row of cells; a search is a wave that enters the first cell and moves one
// cell per clock, carrying the current run of unused blocks, and leaves the last cell
// with the answer. One item is handled at a time. Setting a type, a zero length and an
// unknown action give their result in the cycle after the item is taken. Finding the
// first unused block passes the wave along the whole cell chain. Finding a run first
// runs the bit-serial divider that turns the length into a block count, then the pass
// along the chain. The next item is taken in the cycle after the result has been taken.
// block_size and block_count are written through the APB port at byte addresses 0 and
// 4; the user must write them only while the allocator is idle; nothing enforces it.
`include "contiguous_block_allocator_assert.svh"

module contiguous_block_allocator import cba_pkg::*; #(
  parameter int NBLOCKS = DEF_NBLOCKS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_t              rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int IDX_W = $clog2(NBLOCKS);
  localparam int LEN_W = $clog2(NBLOCKS + 2);
  localparam int IDW   = (IDX_W > BLKID_W) ? IDX_W : BLKID_W;
  localparam int NW    = (LEN_W > BLKID_W) ? LEN_W : BLKID_W;
  localparam int CW    = (LEN_W > COUNT_W) ? LEN_W : COUNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [SIZE_W-1:0]  block_size;
  logic [COUNT_W-1:0] block_count;
  logic [SIZE_W-1:0]  size_eff;
  logic [CW-1:0]      count_ext;
  logic [LEN_W-1:0]   used_n;

  logic [1:0]       state;
  logic             accept;
  logic             launch;
  logic             run_mode;
  logic [LEN_W-1:0] need;
  logic [LEN_W-1:0] need_div;

  logic                wr_en;
  logic [IDW-1:0]      wr_id;
  logic                div_start;
  logic                div_done;
  logic [LENGTH_W-1:0] div_quo;
  logic                div_rem_nz;

  logic             chain_valid [NBLOCKS+1];
  logic             chain_found [NBLOCKS+1];
  logic [LEN_W-1:0] chain_len   [NBLOCKS+1];
  logic [IDX_W-1:0] chain_start [NBLOCKS+1];

  logic [IDW-1:0]     start_ext;
  logic [NW-1:0]      need_ext;
  logic [BLKID_W-1:0] end_calc;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size  <= BLOCK_SIZE_RST;
      block_count <= BLOCK_COUNT_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[ADDR_W-1] == REG_BLOCK_COUNT) begin
        block_count <= pwdata[COUNT_W-1:0];
      end else begin
        block_size <= pwdata[SIZE_W-1:0];
      end
    end
  end

  assign prdata = (paddr[ADDR_W-1] == REG_BLOCK_SIZE) ? DATA_W'(block_size)
                                                      : DATA_W'(block_count);

  assign size_eff  = (block_size == '0) ? SIZE_W'(1) : block_size;
  assign count_ext = CW'(block_count);
  assign used_n    = (count_ext > CW'(NBLOCKS)) ? LEN_W'(NBLOCKS) : LEN_W'(count_ext);

  // Handshake and sequencing.
  assign cmd_ready = (state == ST_IDLE);
  assign rsp_valid = (state == ST_DONE);
  assign accept    = cmd_valid && cmd_ready;
  assign wr_en     = accept && (cmd.action == ACT_SET_TYPE);
  assign wr_id     = IDW'(cmd.block_id);
  assign div_start = accept && (cmd.action == ACT_FIND_RUN) && (cmd.length != '0);

  // Any quotient beyond the chain length can never be met, so it saturates.
  assign need_div = (div_quo > LENGTH_W'(NBLOCKS)) ? LEN_W'(NBLOCKS + 1)
                                                   : LEN_W'(div_quo) + LEN_W'(div_rem_nz);

  assign start_ext = IDW'(chain_start[NBLOCKS]);
  assign need_ext  = NW'(need);
  assign end_calc  = start_ext[BLKID_W-1:0] + need_ext[BLKID_W-1:0] - BLKID_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      launch <= 1'b0;
    end else begin
      launch <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (cmd.action == ACT_FIND_FREE) begin
              launch <= 1'b1;
              state  <= ST_SCAN;
            end else if (div_start) begin
              state <= ST_DIV;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            launch <= 1'b1;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (chain_valid[NBLOCKS]) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (rsp_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status      <= STATUS_OK;
      rsp.start_block <= '0;
      rsp.end_block   <= '0;
      run_mode        <= (cmd.action == ACT_FIND_RUN);
      need            <= LEN_W'(1);
    end else if ((state == ST_DIV) && div_done) begin
      need <= need_div;
    end else if ((state == ST_SCAN) && chain_valid[NBLOCKS]) begin
      if (chain_found[NBLOCKS]) begin
        rsp.status      <= STATUS_OK;
        rsp.start_block <= start_ext[BLKID_W-1:0];
        rsp.end_block   <= run_mode ? end_calc : '0;
      end else begin
        rsp.status      <= STATUS_NO_SPACE;
        rsp.start_block <= '0;
        rsp.end_block   <= '0;
      end
    end
  end

  cba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cmd.length),
    .divisor  (size_eff),
    .done     (div_done),
    .quotient (div_quo),
    .rem_nz   (div_rem_nz)
  );

  // The wave enters with no run in progress.
  assign chain_valid[0] = launch;
  assign chain_found[0] = 1'b0;
  assign chain_len[0]   = '0;
  assign chain_start[0] = '0;

  for (genvar g = 0; g < NBLOCKS; g++) begin : g_cell
    cba_cell #(
      .NBLOCKS (NBLOCKS),
      .INDEX   (g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .wr_en      (wr_en),
      .wr_id      (wr_id),
      .wr_type    (cmd.new_type),
      .need       (need),
      .used       (used_n),
      .prev_valid (chain_valid[g]),
      .prev_found (chain_found[g]),
      .prev_len   (chain_len[g]),
      .prev_start (chain_start[g]),
      .next_valid (chain_valid[g+1]),
      .next_found (chain_found[g+1]),
      .next_len   (chain_len[g+1]),
      .next_start (chain_start[g+1])
    );
  end

  `CBA_ASSERT_IMPL(a_ready_excludes_result, clk, rst, cmd_ready, !rsp_valid)
  `CBA_ASSERT_IMPL(a_wave_exit_in_scan, clk, rst, chain_valid[NBLOCKS], state == ST_SCAN)
  `CBA_ASSERT_IMPL(a_div_done_in_div, clk, rst, div_done, state == ST_DIV)
  `CBA_ASSERT_NEXT(a_launch_single, clk, rst, launch, !launch)
  `CBA_ASSERT_IMPL(a_no_space_zero, clk, rst, rsp_valid && rsp.status == STATUS_NO_SPACE,
                   rsp.start_block == 8'd0 && rsp.end_block == 8'd0)

endmodule
